>>> rtl/rss_pkg.sv
// Shared widths, opcodes and the accumulator state record for the
// running sample statistics block. No dependencies.
package rss_pkg;

	// Field sizing
	localparam int SAMPLE_BITS = 16;
	localparam int COUNT_BITS  = 20;

	// Accumulator widths
	localparam int SUM_W   = SAMPLE_BITS + COUNT_BITS;
	localparam int SUMSQ_W = 2 * SAMPLE_BITS + COUNT_BITS;

	// Fixed point: 8 fraction bits on results, 16 on a radicand
	localparam int MEAN_FRAC = 8;
	localparam int ROOT_FRAC = 2 * MEAN_FRAC;
	localparam int MEAN_W    = SAMPLE_BITS + MEAN_FRAC;
	localparam int RMS_W     = SAMPLE_BITS + MEAN_FRAC - 1;
	localparam int SD_W      = SAMPLE_BITS + MEAN_FRAC;

	// Iterative unit widths
	localparam int RT_W   = SD_W;
	localparam int RAD_W  = 2 * RT_W;
	localparam int MA_W   = SUMSQ_W;
	localparam int MB_W   = SUM_W;
	localparam int PROD_W = SUMSQ_W + COUNT_BITS;
	localparam int DVD_W  = PROD_W + ROOT_FRAC;
	localparam int DVS_W  = 2 * COUNT_BITS;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REPORT = 2'd1,
		OP_CLEAR  = 2'd2
	} opcode_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] run_min;
		logic signed [SAMPLE_BITS-1:0] run_max;
		logic signed [SUM_W-1:0]       run_sum;
		logic [SUMSQ_W-1:0]            run_sumsq;
		logic [COUNT_BITS-1:0]         count;
		logic                          ovf;
	} acc_state_t;

endpackage

>>> rtl/rss_accum.sv
// Sample accumulator: running min, max, sum, sum of squares, count and
// the overflow flag. Depends on rss_pkg.
module rss_accum import rss_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          add_go,
	input  logic                          clr_go,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output acc_state_t                    stats
);

	localparam logic [COUNT_BITS-1:0] COUNT_FULL = '1;
	localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam acc_state_t ACC_CLEAR = '{SMAX, SMIN, '0, '0, '0, 1'b0};

	logic signed [SAMPLE_BITS-1:0] x_s1;
	logic [2*SAMPLE_BITS-1:0]      sq_s1;
	logic                          pend_s1;
	logic [SAMPLE_BITS-1:0]        mag;
	acc_state_t                    stats_q;

	// Magnitude of the sample; the most negative value maps to 2^(N-1)
	assign mag = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;

	// Register the sample and its square
	always_ff @(posedge clk) begin
		if (add_go) begin
			x_s1  <= sample;
			sq_s1 <= (2*SAMPLE_BITS)'(mag) * (2*SAMPLE_BITS)'(mag);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= add_go;
		end
	end

	// Fold the registered sample in, or drop it when the count is full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stats_q <= ACC_CLEAR;
		end else if (clr_go) begin
			stats_q <= ACC_CLEAR;
		end else if (pend_s1) begin
			if (stats_q.count == COUNT_FULL) begin
				stats_q.ovf <= 1'b1;
			end else begin
				if (x_s1 < stats_q.run_min) begin
					stats_q.run_min <= x_s1;
				end
				if (x_s1 > stats_q.run_max) begin
					stats_q.run_max <= x_s1;
				end
				stats_q.run_sum   <= stats_q.run_sum + SUM_W'(x_s1);
				stats_q.run_sumsq <= stats_q.run_sumsq + SUMSQ_W'(sq_s1);
				stats_q.count     <= stats_q.count + 1'b1;
			end
		end
	end

	assign stats = stats_q;

endmodule

>>> rtl/rss_mul.sv
// Shift-and-add multiplier, one multiplier bit per cycle.
// Depends on rss_pkg.
module rss_mul import rss_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [MA_W-1:0]   a,
	input  logic [MB_W-1:0]   b,
	output logic              done,
	output logic [PROD_W-1:0] product
);

	localparam int CNT_W = $clog2(MB_W);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(MB_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MA_W-1:0]  a_q;
	logic [MA_W-1:0]  hi_q;
	logic [MB_W-1:0]  lo_q;
	logic [MA_W:0]    sum_w;
	logic [MA_W+MB_W-1:0] full_w;

	// Add the multiplicand when the low multiplier bit is set
	assign sum_w = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Shift the partial product right, new bits fill the multiplier slot
	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (busy_q) begin
			hi_q <= sum_w[MA_W:1];
			lo_q <= {sum_w[0], lo_q[MB_W-1:1]};
		end
	end

	assign full_w  = {hi_q, lo_q};
	assign product = full_w[PROD_W-1:0];
	assign done    = done_q;

endmodule

>>> rtl/rss_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on rss_pkg.
module rss_div import rss_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(DVD_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W:0]   trial_w;
	logic [DVS_W:0]   diff_w;
	logic             ge_w;

	// Bring down the next dividend bit and try the subtract
	assign trial_w = {rem_q, quo_q[DVD_W-1]};
	assign diff_w  = trial_w - {1'b0, dvs_q};
	assign ge_w    = trial_w >= {1'b0, dvs_q};

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Dividend shifts out at the top, quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge_w ? diff_w[DVS_W-1:0] : trial_w[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge_w};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

>>> rtl/rss_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle, floored.
// Depends on rss_pkg.
module rss_sqrt import rss_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [RAD_W-1:0] radicand,
	output logic             done,
	output logic [RT_W-1:0]  root
);

	localparam int CNT_W = $clog2(RT_W);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(RT_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [RAD_W-1:0] rad_q;
	logic [RT_W-1:0]  rem_q;
	logic [RT_W-1:0]  root_q;
	logic [RT_W+1:0]  part_w;
	logic [RT_W+1:0]  test_w;
	logic [RT_W+1:0]  diff_w;
	logic             ge_w;

	// Bring down two radicand bits and test root*4+1
	assign part_w = {rem_q, rad_q[RAD_W-1:RAD_W-2]};
	assign test_w = {root_q, 2'b01};
	assign diff_w = part_w - test_w;
	assign ge_w   = part_w >= test_w;

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Advance one root bit
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= ge_w ? diff_w[RT_W-1:0] : part_w[RT_W-1:0];
			root_q <= {root_q[RT_W-2:0], ge_w};
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule

>>> rtl/running_sample_statistics.sv
// Running sample statistics top level: command sequencer, result register
// and the shared multiplier, divider and root units.
// Depends on rss_pkg, rss_accum, rss_mul, rss_div, rss_sqrt.
//
//  channel  signals                 payload
//  -------  ----------------------  -------------------------------------------
//  command  cmd_valid / cmd_ready   opcode, sample
//  result   res_valid / res_ready   status, sample_count, minimum, maximum,
//                                   mean_value, rms_value, std_deviation,
//                                   overflowed
//
// An add, a clear and a report of an empty set need no shared unit. A
// report of one sample runs the 88-step divider twice and the 24-step root
// once; a report of two or more runs the divider up to three times, the
// 36-step multiplier up to three times and the root at most twice.
// cmd_ready is high only while the sequencer is idle. A finished report
// waits in the sequencer until the result register is free; no command is
// taken while it waits. Reset clears the set and the flag.
module running_sample_statistics import rss_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_ready,
	input  logic [1:0]                    opcode,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic                          status,
	output logic [COUNT_BITS-1:0]         sample_count,
	output logic signed [SAMPLE_BITS-1:0] minimum,
	output logic signed [SAMPLE_BITS-1:0] maximum,
	output logic signed [MEAN_W-1:0]      mean_value,
	output logic [RMS_W-1:0]              rms_value,
	output logic [SD_W-1:0]               std_deviation,
	output logic                          overflowed
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_ADD,
		ST_MEAN, ST_MEAN_W,
		ST_RMS, ST_RMS_W, ST_RMS_RT, ST_RMS_RT_W,
		ST_MUL_A, ST_MUL_A_W, ST_MUL_B, ST_MUL_B_W, ST_MUL_N, ST_MUL_N_W,
		ST_SD, ST_SD_W, ST_SD_RT, ST_SD_RT_W,
		ST_DONE
	} state_t;

	localparam logic [DVD_W-1:0] MEAN_NEG_LIM =
		{{(DVD_W-MEAN_W){1'b0}}, 1'b1, {(MEAN_W-1){1'b0}}};
	localparam logic [DVD_W-1:0] MEAN_POS_LIM =
		{{(DVD_W-MEAN_W+1){1'b0}}, {(MEAN_W-1){1'b1}}};

	state_t            state_q;
	logic              res_valid_q;
	logic              status_q;
	logic [COUNT_BITS-1:0] count_q;
	logic signed [SAMPLE_BITS-1:0] min_q;
	logic signed [SAMPLE_BITS-1:0] max_q;
	logic [MEAN_W-1:0] out_mean_q;
	logic [RMS_W-1:0]  out_rms_q;
	logic [SD_W-1:0]   out_sd_q;
	logic              ovf_q;

	logic [MEAN_W-1:0] mean_q;
	logic [RMS_W-1:0]  rms_q;
	logic [SD_W-1:0]   sd_q;
	logic [PROD_W-1:0] a_q;
	logic [PROD_W-1:0] d_q;

	acc_state_t        stats;
	logic              accept_w;
	logic              add_go;
	logic              clr_go;
	logic              neg_w;
	logic [SUM_W-1:0]  smag_w;
	logic              res_load_w;

	logic              mul_go;
	logic [MA_W-1:0]   mul_a;
	logic [MB_W-1:0]   mul_b;
	logic              mul_done;
	logic [PROD_W-1:0] mul_prod;

	logic              div_go;
	logic [DVD_W-1:0]  div_dvd;
	logic [DVS_W-1:0]  div_dvs;
	logic              div_done;
	logic [DVD_W-1:0]  div_quo;

	logic              sqrt_go;
	logic [RAD_W-1:0]  sqrt_rad;
	logic              sqrt_done;
	logic [RT_W-1:0]   sqrt_root;

	logic [MEAN_W-1:0] mean_mag_w;
	logic [MEAN_W-1:0] mean_w;
	logic [RMS_W-1:0]  rms_w;
	logic              brw_w;
	logic [PROD_W-1:0] dif_w;

	// Command transfer
	assign cmd_ready = (state_q == ST_IDLE);
	assign accept_w  = cmd_valid && cmd_ready;
	assign add_go    = accept_w && (opcode == OP_ADD);
	assign clr_go    = accept_w && (opcode == OP_CLEAR);

	// Load the result register once it is free
	assign res_load_w = (state_q == ST_DONE) && (!res_valid_q || res_ready);

	rss_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.add_go (add_go),
		.clr_go (clr_go),
		.sample (sample),
		.stats  (stats)
	);

	// Sign and magnitude of the running sum
	assign neg_w  = stats.run_sum[SUM_W-1];
	assign smag_w = neg_w ? (~stats.run_sum + 1'b1) : stats.run_sum;

	// Operand selection for the shared units
	always_comb begin
		mul_go  = 1'b0;
		mul_a   = '0;
		mul_b   = '0;
		div_go  = 1'b0;
		div_dvd = '0;
		div_dvs = DVS_W'(stats.count);
		case (state_q)
			ST_MEAN: begin
				div_go  = 1'b1;
				div_dvd = DVD_W'({smag_w, {MEAN_FRAC{1'b0}}});
			end
			ST_RMS: begin
				div_go  = 1'b1;
				div_dvd = DVD_W'({stats.run_sumsq, {ROOT_FRAC{1'b0}}});
			end
			ST_MUL_A: begin
				mul_go = 1'b1;
				mul_a  = stats.run_sumsq;
				mul_b  = MB_W'(stats.count);
			end
			ST_MUL_B: begin
				mul_go = 1'b1;
				mul_a  = MA_W'(smag_w);
				mul_b  = smag_w;
			end
			ST_MUL_N: begin
				mul_go = 1'b1;
				mul_a  = MA_W'(stats.count);
				mul_b  = MB_W'(stats.count - 1'b1);
			end
			ST_SD: begin
				div_go  = 1'b1;
				div_dvd = {d_q, {ROOT_FRAC{1'b0}}};
				div_dvs = mul_prod[DVS_W-1:0];
			end
			default: begin
			end
		endcase
	end

	assign sqrt_go  = (state_q == ST_RMS_RT) || (state_q == ST_SD_RT);
	assign sqrt_rad = (|div_quo[DVD_W-1:RAD_W]) ? '1 : div_quo[RAD_W-1:0];

	rss_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_go),
		.a       (mul_a),
		.b       (mul_b),
		.done    (mul_done),
		.product (mul_prod)
	);

	rss_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	rss_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_go),
		.radicand (sqrt_rad),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	// Saturate the mean magnitude and restore the sign
	always_comb begin
		if (neg_w) begin
			mean_mag_w = (div_quo > MEAN_NEG_LIM) ? MEAN_NEG_LIM[MEAN_W-1:0]
				: div_quo[MEAN_W-1:0];
			mean_w = ~mean_mag_w + 1'b1;
		end else begin
			mean_mag_w = (div_quo > MEAN_POS_LIM) ? MEAN_POS_LIM[MEAN_W-1:0]
				: div_quo[MEAN_W-1:0];
			mean_w = mean_mag_w;
		end
	end

	// Clip the rms root to its field
	assign rms_w = sqrt_root[RT_W-1] ? '1 : sqrt_root[RMS_W-1:0];

	// n*sumsq - sum^2, with borrow
	assign {brw_w, dif_w} = {1'b0, a_q} - {1'b0, mul_prod};

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			status_q    <= 1'b0;
			count_q     <= '0;
			min_q       <= '0;
			max_q       <= '0;
			out_mean_q  <= '0;
			out_rms_q   <= '0;
			out_sd_q    <= '0;
			ovf_q       <= 1'b0;
			mean_q      <= '0;
			rms_q       <= '0;
			sd_q        <= '0;
			a_q         <= '0;
			d_q         <= '0;
		end else begin
			// Raise valid on a load, drop it after the transfer
			if (res_load_w) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						case (opcode)
							OP_ADD: begin
								state_q <= ST_ADD;
							end
							OP_REPORT: begin
								if (stats.count == '0) begin
									mean_q  <= '0;
									rms_q   <= '0;
									sd_q    <= '0;
									state_q <= ST_DONE;
								end else begin
									state_q <= ST_MEAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_ADD: state_q <= ST_IDLE;
				ST_MEAN: state_q <= ST_MEAN_W;
				ST_MEAN_W: begin
					if (div_done) begin
						mean_q  <= mean_w;
						state_q <= ST_RMS;
					end
				end
				ST_RMS: state_q <= ST_RMS_W;
				ST_RMS_W: begin
					if (div_done) begin
						state_q <= ST_RMS_RT;
					end
				end
				ST_RMS_RT: state_q <= ST_RMS_RT_W;
				ST_RMS_RT_W: begin
					if (sqrt_done) begin
						rms_q <= rms_w;
						if (stats.count > COUNT_BITS'(1)) begin
							state_q <= ST_MUL_A;
						end else begin
							sd_q    <= '0;
							state_q <= ST_DONE;
						end
					end
				end
				ST_MUL_A: state_q <= ST_MUL_A_W;
				ST_MUL_A_W: begin
					if (mul_done) begin
						a_q     <= mul_prod;
						state_q <= ST_MUL_B;
					end
				end
				ST_MUL_B: state_q <= ST_MUL_B_W;
				ST_MUL_B_W: begin
					// Drop to zero deviation unless the variance is positive
					if (mul_done) begin
						if (!brw_w && (dif_w != '0)) begin
							d_q     <= dif_w;
							state_q <= ST_MUL_N;
						end else begin
							sd_q    <= '0;
							state_q <= ST_DONE;
						end
					end
				end
				ST_MUL_N: state_q <= ST_MUL_N_W;
				ST_MUL_N_W: begin
					if (mul_done) begin
						state_q <= ST_SD;
					end
				end
				ST_SD: state_q <= ST_SD_W;
				ST_SD_W: begin
					if (div_done) begin
						state_q <= ST_SD_RT;
					end
				end
				ST_SD_RT: state_q <= ST_SD_RT_W;
				ST_SD_RT_W: begin
					if (sqrt_done) begin
						sd_q    <= sqrt_root;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// Hold until the result register is free
					if (res_load_w) begin
						status_q    <= (stats.count != '0);
						count_q     <= stats.count;
						min_q       <= stats.run_min;
						max_q       <= stats.run_max;
						out_mean_q  <= mean_q;
						out_rms_q   <= rms_q;
						out_sd_q    <= sd_q;
						ovf_q       <= stats.ovf;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_valid     = res_valid_q;
	assign status        = status_q;
	assign sample_count  = count_q;
	assign minimum       = min_q;
	assign maximum       = max_q;
	assign mean_value    = out_mean_q;
	assign rms_value     = out_rms_q;
	assign std_deviation = out_sd_q;
	assign overflowed    = ovf_q;

endmodule
